// ----- hw/rtl/tlblru_pkg.sv -----
// shared constants, codes and transaction types for the lru translation buffer
// used by every module of the block; depends on nothing
`default_nettype none

package tlblru_pkg;

  localparam int ENTRIES    = 128;
  localparam int PAGE_SIZE  = 4;
  localparam int AGE_W      = 16;

  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);

  localparam int SID_W      = 4;
  localparam int ADDR_W     = 22;
  localparam int FRAME_W    = 20;
  localparam int PERM_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 7;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRAP = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_NUM_PROC = 2'd0;
  localparam logic [SID_W-1:0]      NUM_PROC_RST = 4'd15;

  typedef struct packed {
    logic [SID_W-1:0]   space_id;
    logic [ADDR_W-1:0]  address;
    logic [FRAME_W-1:0] fill_frame;
    logic [PERM_W-1:0]  fill_perm;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [FRAME_W-1:0]  frame;
    logic [PERM_W-1:0]   perm;
  } out_t;

  // lookup token that walks the cell row
  typedef struct packed {
    logic               vld;
    logic [SID_W-1:0]   sid;
    logic [PAGE_W-1:0]  page;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [FRAME_W-1:0] hit_frame;
    logic [PERM_W-1:0]  hit_perm;
    logic [AGE_W-1:0]   best_age;
    logic [IDX_W-1:0]   best_idx;
  } tok_t;

  // refill broadcast to all cells
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [SID_W-1:0]   sid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic [PERM_W-1:0]  perm;
  } wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tlblru_cell.sv -----
// one buffer entry: tag, frame, permissions and age, plus one stage of the lookup token
// depends on tlblru_pkg
`default_nettype none

module tlblru_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire [tlblru_pkg::IDX_W-1:0] cell_idx,
  input  wire tlblru_pkg::tok_t       tok_in,
  input  wire tlblru_pkg::wr_t        wr,
  output tlblru_pkg::tok_t            tok_out
);
  import tlblru_pkg::*;

  logic               valid_r;
  logic [SID_W-1:0]   space_r;
  logic [PAGE_W-1:0]  page_r;
  logic [FRAME_W-1:0] frame_r;
  logic [PERM_W-1:0]  perm_r;
  logic [AGE_W-1:0]   age_r;
  logic [AGE_W-1:0]   age_nxt;
  logic [AGE_W-1:0]   age_inc;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic               match;
  logic               take_hit;
  logic               wr_sel;

  always_comb begin
    match    = valid_r && (space_r == tok_in.sid) && (page_r == tok_in.page);
    // only the first matching entry along the row counts as the hit
    take_hit = tok_in.vld && match && !tok_in.hit;
    age_inc  = (age_r == AGE_MAX) ? age_r : age_r + AGE_W'(1);
    age_nxt  = take_hit ? '0 : age_inc;
    wr_sel   = wr.en && (wr.idx == cell_idx);

    tok_nxt = tok_in;
    if (take_hit) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.hit_idx   = cell_idx;
      tok_nxt.hit_frame = frame_r;
      tok_nxt.hit_perm  = perm_r;
    end
    // strictly greater keeps the lowest index on a tie
    if (tok_in.vld && (age_nxt > tok_in.best_age)) begin
      tok_nxt.best_age = age_nxt;
      tok_nxt.best_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (wr_sel) begin
        valid_r <= 1'b1;
        age_r   <= '0;
      end else if (tok_in.vld) begin
        age_r <= age_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      space_r <= wr.sid;
      page_r  <= wr.page;
      frame_r <= wr.frame;
      perm_r  <= wr.perm;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ----- hw/rtl/tlb_lookup_lru_replace.sv -----
// fully associative translation buffer with age-counter lru replacement
// in_valid/in_stall/in_data carry a request: space id, address and the page-walk fill
// used on a miss; out_valid/out_stall/out_data carry one result per request: hit, miss
// with refill, or trap; a transaction happens at a rising edge with valid high, stall low
// entries sit in a row of ENTRIES cells; a lookup token walks the row one cell per cycle,
// comparing tags, aging entries and tracking the oldest one; a miss then refills the
// victim by a broadcast write
// the row walk sets the timing: a lookup passes the head register, the cell
// registers of the row, the holding register and the output register on its way to
// out_valid; the next request is taken once the previous result has left the holding
// register; a trapping request (space id zero or above num_processes) skips the row
// and loads the holding register directly
// one finished result can wait in a holding register while the output register is
// stalled; requests are held off while a walk is in flight or the holding register is full
// reset (rst_n low, synchronous) invalidates all entries, clears all ages and sets
// num_processes to 15; num_processes sits at byte address 0 of the psel/penable port;
// the user must write it only while the block is idle, which the block does not enforce
// depends on tlblru_pkg and tlblru_cell
`default_nettype none

module tlb_lookup_lru_replace (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire tlblru_pkg::in_t             in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output tlblru_pkg::out_t                 out_data,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [tlblru_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire [tlblru_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tlblru_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import tlblru_pkg::*;

  logic [SID_W-1:0]   num_proc_r;
  logic               busy_r;
  logic               res_vld_r;
  out_t               res_r;
  logic               out_vld_r;
  out_t               out_r;
  tok_t               head_r;
  wr_t                wr_r;
  wr_t                wr_nxt;
  logic [FRAME_W-1:0] fill_frame_r;
  logic [PERM_W-1:0]  fill_perm_r;
  tok_t               chain [ENTRIES+1];
  tok_t               tail;
  tok_t               head_nxt;
  out_t               res_nxt;
  logic               in_acc;
  logic               trap;
  logic               res_load;
  logic               res_move;
  logic               cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_NUM_PROC);
  assign prdata = (paddr == REG_NUM_PROC) ? CFG_DATA_W'(num_proc_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_proc_r <= NUM_PROC_RST;
    end else if (cfg_wr) begin
      num_proc_r <= pwdata[SID_W-1:0];
    end
  end

  // cell row
  assign chain[0] = head_r;
  assign tail     = chain[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tlblru_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .tok_in   (chain[g]),
      .wr       (wr_r),
      .tok_out  (chain[g+1])
    );
  end

  // request side
  assign in_stall = busy_r || res_vld_r;
  assign in_acc   = in_valid && !in_stall;
  assign trap     = (in_data.space_id == '0) || (in_data.space_id > num_proc_r);

  always_comb begin
    head_nxt          = '0;
    head_nxt.vld      = in_acc && !trap;
    head_nxt.sid      = in_data.space_id;
    head_nxt.page     = in_data.address[ADDR_W-1:PAGE_SHIFT];

    wr_nxt            = '0;
    wr_nxt.en         = tail.vld && !tail.hit;
    wr_nxt.idx        = tail.best_idx;
    wr_nxt.sid        = tail.sid;
    wr_nxt.page       = tail.page;
    wr_nxt.frame      = fill_frame_r;
    wr_nxt.perm       = fill_perm_r;

    res_nxt = '0;
    if (tail.vld) begin
      if (tail.hit) begin
        res_nxt.status = ST_HIT;
        res_nxt.slot   = SLOT_W'(tail.hit_idx);
        res_nxt.frame  = tail.hit_frame;
        res_nxt.perm   = tail.hit_perm;
      end else begin
        res_nxt.status = ST_MISS;
        res_nxt.slot   = SLOT_W'(tail.best_idx);
        res_nxt.frame  = fill_frame_r;
        res_nxt.perm   = fill_perm_r;
      end
    end else begin
      res_nxt.status = ST_TRAP;
    end

    res_load = tail.vld || (in_acc && trap);
    res_move = res_vld_r && (!out_vld_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      wr_r      <= '0;
      busy_r    <= 1'b0;
      res_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      wr_r   <= wr_nxt;
      if (in_acc && !trap) begin
        busy_r <= 1'b1;
      end else if (tail.vld) begin
        busy_r <= 1'b0;
      end
      if (res_load) begin
        res_vld_r <= 1'b1;
      end else if (res_move) begin
        res_vld_r <= 1'b0;
      end
      if (!out_vld_r || !out_stall) begin
        out_vld_r <= res_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fill_frame_r <= in_data.fill_frame;
      fill_perm_r  <= in_data.fill_perm;
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
    if (res_move) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- hw/rtl/tlblru_checker.sv -----
// port-level checks for tlb_lookup_lru_replace, attached by bind
// depends on tlblru_pkg
`default_nettype none

module tlblru_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_valid,
  input wire                               in_stall,
  input wire tlblru_pkg::in_t              in_data,
  input wire                               out_valid,
  input wire                               out_stall,
  input wire tlblru_pkg::out_t             out_data,
  input wire                               pready
);
  import tlblru_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // only hit, miss and trap codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_HIT) || (out_data.status == ST_MISS) ||
                  (out_data.status == ST_TRAP))
    else $error("unknown status code");

  // a trap carries no translation
  a_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_TRAP) |->
      (out_data.slot == '0) && (out_data.frame == '0) && (out_data.perm == '0))
    else $error("trap result with nonzero fields");

  // one request in flight: the block holds off right after taking one
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port not ready");

endmodule

bind tlb_lookup_lru_replace tlblru_checker u_tlblru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);

`default_nettype wire

// ----- verif/tlb_lookup_lru_replace_checker.sv -----
`timescale 1ns / 100ps
// checker for the lru translation buffer: watches both channels and the register port,
// predicts every result and compares it against what the block returns
// depends on tlblru_pkg

module tlb_lookup_lru_replace_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  input  wire                              in_stall,
  input  tlblru_pkg::in_t                  in_data,
  input  wire                              out_valid,
  input  wire                              out_stall,
  input  tlblru_pkg::out_t                 out_data,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [tlblru_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire [tlblru_pkg::CFG_DATA_W-1:0] pwdata,
  input  wire                              pready,
  output int                               errors,
  output int                               pending
);
  import tlblru_pkg::*;

  logic               tag_valid  [ENTRIES];
  logic [SID_W-1:0]   tag_space  [ENTRIES];
  logic [PAGE_W-1:0]  tag_page   [ENTRIES];
  logic [FRAME_W-1:0] ent_frame  [ENTRIES];
  logic [PERM_W-1:0]  ent_perm   [ENTRIES];
  logic [AGE_W-1:0]   ent_age    [ENTRIES];
  logic [SID_W-1:0]   nproc_limit;

  out_t translations[$];

  task automatic clear_buffer();
    for (int i = 0; i < ENTRIES; i++) begin
      tag_valid[i] = 1'b0;
      tag_space[i] = '0;
      tag_page[i]  = '0;
      ent_frame[i] = '0;
      ent_perm[i]  = '0;
      ent_age[i]   = '0;
    end
    nproc_limit = NUM_PROC_RST;
  endtask

  // one lookup: updates the buffer copy and yields the result it must produce
  task automatic translate(input in_t req, output out_t res);
    logic [PAGE_W-1:0] page;
    int hit_idx;
    int victim;
    res = '0;
    if (req.space_id == '0 || req.space_id > nproc_limit) begin
      res.status = ST_TRAP;
    end else begin
      page    = PAGE_W'(req.address / PAGE_SIZE);
      hit_idx = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_idx < 0 && tag_valid[i] && tag_space[i] == req.space_id && tag_page[i] == page)
          hit_idx = i;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (i != hit_idx && ent_age[i] != AGE_MAX) ent_age[i] = ent_age[i] + 1'b1;
      end
      if (hit_idx >= 0) begin
        ent_age[hit_idx] = '0;
        res.status = ST_HIT;
        res.slot   = hit_idx[SLOT_W-1:0];
        res.frame  = ent_frame[hit_idx];
        res.perm   = ent_perm[hit_idx];
      end else begin
        // oldest entry wins, lowest index on a tie
        victim = 0;
        for (int i = 1; i < ENTRIES; i++) begin
          if (ent_age[i] > ent_age[victim]) victim = i;
        end
        tag_valid[victim] = 1'b1;
        tag_space[victim] = req.space_id;
        tag_page[victim]  = page;
        ent_frame[victim] = req.fill_frame;
        ent_perm[victim]  = req.fill_perm;
        ent_age[victim]   = '0;
        res.status = ST_MISS;
        res.slot   = victim[SLOT_W-1:0];
        res.frame  = req.fill_frame;
        res.perm   = req.fill_perm;
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    out_t next_res;
    if (!rst_n) begin
      clear_buffer();
      translations.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_NUM_PROC)
        nproc_limit = pwdata[SID_W-1:0];
      if (out_valid && !out_stall) begin
        if (translations.size() == 0) begin
          errors++;
          $display("%0t: expected no result, got status=%0d slot=%0d frame=%h perm=%0d",
                   $time, out_data.status, out_data.slot, out_data.frame, out_data.perm);
        end else begin
          want = translations.pop_front();
          if (out_data !== want) begin
            errors++;
            $display("%0t: expected %0d/%0d/%h/%0d got %0d/%0d/%h/%0d (status/slot/frame/perm)",
                     $time, want.status, want.slot, want.frame, want.perm,
                     out_data.status, out_data.slot, out_data.frame, out_data.perm);
          end
        end
      end
      if (in_valid && !in_stall) begin
        translate(in_data, next_res);
        translations = {translations, next_res};
      end
    end
    pending = translations.size();
  end

endmodule

// ----- verif/tlb_lookup_lru_replace_test.sv -----
`timescale 1ns / 100ps
// top of the lru translation buffer testbench: clock, reset, request stimulus, receiver
// stalls and register writes; depends on tlblru_pkg, the block and its checker

module tlb_lookup_lru_replace_test;
  import tlblru_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = ENTRIES + 10;
  localparam int PHASE_ITEMS   = 256;
  localparam int POOL_DEPTH    = 160;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int errors;
  int pending;
  int idle_cycles = 0;
  int burst_left  = 0;
  int cur_nproc   = NUM_PROC_RST;
  in_t page_pool[$];

  tlb_lookup_lru_replace u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tlb_lookup_lru_replace_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls in runs, with a mode that drifts between none, light and heavy
  int  stall_run  = 0;
  int  stall_mode = 0;
  logic stall_lvl = 1'b0;
  always @(negedge clk) begin
    if (stall_run == 0) begin
      if ($urandom_range(0, 7) == 0) stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(1, 20);
      case (stall_mode)
        0: begin
          stall_lvl = 1'b0;
        end
        1: begin
          stall_lvl = ($urandom_range(0, 3) == 0);
        end
        default: begin
          stall_lvl = ($urandom_range(0, 1) == 0);
        end
      endcase
    end
    stall_run--;
    out_stall <= stall_lvl;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic in_t make_req(int sid, int addr, int frame, int perm);
    in_t r;
    r.space_id   = sid[SID_W-1:0];
    r.address    = addr[ADDR_W-1:0];
    r.fill_frame = frame[FRAME_W-1:0];
    r.fill_perm  = perm[PERM_W-1:0];
    return r;
  endfunction

  // bursts of back-to-back transactions separated by random gaps
  task automatic send_req(input in_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic send_random_req();
    in_t req;
    int  r;
    int  pick;
    req.address    = ADDR_W'($urandom);
    req.fill_frame = FRAME_W'($urandom);
    req.fill_perm  = PERM_W'($urandom);
    req.space_id   = '0;
    r = $urandom_range(0, 99);
    if (cur_nproc == 0 || r < 10) begin
      if (cur_nproc < 15 && $urandom_range(0, 1) == 0)
        req.space_id = SID_W'($urandom_range(cur_nproc + 1, 15));
    end else if (r < 70 && page_pool.size() > 0) begin
      // revisit a known page with a fresh offset; some with another space id
      pick = $urandom_range(0, page_pool.size() - 1);
      req.space_id = page_pool[pick].space_id;
      req.address  = {page_pool[pick].address[ADDR_W-1:PAGE_SHIFT],
                      req.address[PAGE_SHIFT-1:0]};
      if (r >= 60) req.space_id = SID_W'($urandom_range(1, cur_nproc));
    end else begin
      req.space_id = SID_W'($urandom_range(1, cur_nproc));
      page_pool = {page_pool, req};
      if (page_pool.size() > POOL_DEPTH) void'(page_pool.pop_front());
    end
    send_req(req);
  endtask

  // let every result come back, then give the row walk time to finish
  task automatic drain();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_nproc(input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_NUM_PROC;
    pwdata  <= ($urandom & 32'hFFFF_FFF0) | value[SID_W-1:0];
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_nproc = value;
  endtask

  initial begin
    int phase_nproc[5];
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: traps on id zero, hits within a page, space id and field extremes
    send_req(make_req(0, 0, 'hFFFFF, 7));
    send_req(make_req(0, 'h3FFFFF, 0, 0));
    send_req(make_req(15, 0, 0, 0));
    send_req(make_req(15, 3, 'hFFFFF, 7));
    send_req(make_req(15, 4, 'h12345, 5));
    send_req(make_req(1, 0, 'hFFFFF, 7));
    send_req(make_req(15, 'h3FFFFF, 'hFFFFF, 7));
    send_req(make_req(15, 'h3FFFFC, 0, 0));
    send_req(make_req(1, 1, 0, 0));
    for (int p = 0; p < 8; p++)
      send_req(make_req(8, 100 + 4 * p, $urandom, p));
    send_req(make_req(15, 2, 0, 0));
    drain();

    write_nproc(1);
    send_req(make_req(1, 0, 0, 0));
    send_req(make_req(2, 0, 0, 0));
    send_req(make_req(15, 'h3FFFFF, 0, 0));
    drain();

    // register value zero traps everything
    write_nproc(0);
    send_req(make_req(1, 0, 0, 0));
    send_req(make_req(15, 4, 0, 0));
    send_req(make_req(0, 0, 0, 0));
    drain();

    phase_nproc[0] = 15;
    phase_nproc[1] = 1;
    phase_nproc[2] = $urandom_range(2, 14);
    phase_nproc[3] = $urandom_range(1, 14);
    phase_nproc[4] = 15;
    for (int ph = 0; ph < 5; ph++) begin
      write_nproc(phase_nproc[ph]);
      repeat (PHASE_ITEMS) send_random_req();
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tlblru_pkg.sv
hw/rtl/tlblru_cell.sv
hw/rtl/tlb_lookup_lru_replace.sv
hw/rtl/tlblru_checker.sv
verif/tlb_lookup_lru_replace_checker.sv
verif/tlb_lookup_lru_replace_test.sv
